[hw/rtl/scrolling_text_window_assert.svh]
// assertion macros for the marquee scroller checker
`ifndef SCROLLING_TEXT_WINDOW_ASSERT_SVH
`define SCROLLING_TEXT_WINDOW_ASSERT_SVH

// same-cycle implication
`define STW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/stw_pkg.sv]
package stw_pkg;

	localparam int TEXT_DEPTH = 256;
	localparam int MAX_WINDOW = 32;

	localparam int ADDR_W  = $clog2(TEXT_DEPTH);
	localparam int LEN_W   = $clog2(TEXT_DEPTH + 1);
	localparam int COL_W   = $clog2(MAX_WINDOW);
	localparam int WID_W   = $clog2(MAX_WINDOW + 1);
	// wide enough for text length and for gap plus window
	localparam int CMP_W   = ((LEN_W > 7) ? LEN_W : 7) + 1;
	localparam int CHAR_W  = 8;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_COMMIT = 2'd1,
		KIND_TICK   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_WINDOW_WIDTH = 2'd0,
		REG_GAP_LENGTH   = 2'd1,
		REG_STEP_DIVIDE  = 2'd2,
		REG_EDGE_PAUSE   = 2'd3
	} reg_idx_t;

	// scroll snapshot handed to the frame sequencer at a tick
	typedef struct packed {
		logic [ADDR_W-1:0] pos;
		logic [LEN_W-1:0]  rem;
		logic              fits;
		logic [WID_W-1:0]  width;
	} frame_req_t;

	function automatic logic [WID_W-1:0] eff_width(input logic [5:0] ww);
		logic [WID_W-1:0] w;
		if (ww == 6'd0)
			w = WID_W'(1);
		else if (int'(ww) > MAX_WINDOW)
			w = WID_W'(MAX_WINDOW);
		else
			w = WID_W'(ww);
		return w;
	endfunction

endpackage

[hw/rtl/scrolling_text_window.sv]
// text marquee scroller. a write request (kind write) stores one character in the
// 256-entry text store and a commit request sets the text length (gap included)
// and may restart the scroll; neither makes the block busy. a tick request emits
// one frame as separate column results, as many as the effective window width
// (window_width, with 0 read as 1 and above 32 read as 32), one column per cycle
// while results do not stall; every column is one read of the single read port of
// the text store. the block is busy until the last read is issued, and each read
// passes the read and result registers. stalls on the result side
// stretch the frame by the stall length. the scroll state (position, pause and
// divider counts) advances at the accepting edge of each tick, and the frame shows
// the position as it stood before that step. the text store has no reset and needs
// no clearing pass; entries must be written before a frame shows them.
// configuration registers sit on the apb port at byte offsets 0, 4, 8 and 12
// (window width, gap length, step divide, edge pause) and may only be written
// while no frame is in flight.
module scrolling_text_window import stw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,

	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         kind,
	input  logic [7:0]         position,
	input  logic [7:0]         char_value,
	input  logic [8:0]         new_length,
	input  logic               restart,

	output logic               result_valid,
	input  logic               result_ready,
	output logic [7:0]         out_char,
	output logic               char_valid,
	output logic               last_column
);

	// configuration registers
	logic [5:0] window_width_q;
	logic [3:0] gap_length_q;
	logic [7:0] step_divide_q;
	logic [7:0] edge_pause_q;

	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	logic              accept;
	logic              wr_en;
	logic              commit_en;
	logic              tick_en;
	logic              busy;

	frame_req_t        snap;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [CHAR_W-1:0] rd_data;

	// apb side, zero wait states
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_width_q <= 6'd16;
			gap_length_q   <= 4'd4;
			step_divide_q  <= 8'd8;
			edge_pause_q   <= 8'd10;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WINDOW_WIDTH: window_width_q <= pwdata[5:0];
				REG_GAP_LENGTH:   gap_length_q   <= pwdata[3:0];
				REG_STEP_DIVIDE:  step_divide_q  <= pwdata[7:0];
				REG_EDGE_PAUSE:   edge_pause_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_WINDOW_WIDTH: prdata = PDATA_W'(window_width_q);
			REG_GAP_LENGTH:   prdata = PDATA_W'(gap_length_q);
			REG_STEP_DIVIDE:  prdata = PDATA_W'(step_divide_q);
			REG_EDGE_PAUSE:   prdata = PDATA_W'(edge_pause_q);
			default:          prdata = '0;
		endcase
	end

	// request decode; kind 3 is accepted and dropped
	assign item_ready = !busy;
	assign accept     = item_valid && item_ready;
	assign wr_en      = accept && (kind == KIND_WRITE);
	assign commit_en  = accept && (kind == KIND_COMMIT);
	assign tick_en    = accept && (kind == KIND_TICK);

	// text store: written by requests, read by the frame sequencer
	stw_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (TEXT_DEPTH)
	) u_text_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ADDR_W'(position)),
		.wdata (char_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// scroll position, pause and divider
	stw_scroll u_scroll (
		.clk         (clk),
		.arst_n      (arst_n),
		.commit_en   (commit_en),
		.new_length  (new_length),
		.restart     (restart),
		.tick_en     (tick_en),
		.width       (eff_width(window_width_q)),
		.gap         (gap_length_q),
		.step_divide (step_divide_q),
		.edge_pause  (edge_pause_q),
		.snap        (snap)
	);

	// one column per cycle out of the store while results do not stall
	stw_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (tick_en),
		.snap         (snap),
		.busy         (busy),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_char     (out_char),
		.char_valid   (char_valid),
		.last_column  (last_column)
	);

endmodule

[hw/rtl/stw_ram.sv]
module stw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[hw/rtl/stw_scroll.sv]
module stw_scroll import stw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             commit_en,
	input  logic [8:0]       new_length,
	input  logic             restart,
	input  logic             tick_en,
	input  logic [WID_W-1:0] width,
	input  logic [3:0]       gap,
	input  logic [7:0]       step_divide,
	input  logic [7:0]       edge_pause,
	output frame_req_t       snap
);

	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] pos_q;
	logic [7:0]        pause_q;
	logic [7:0]        tick_q;

	logic [LEN_W-1:0]  rem;
	logic              fits;
	logic              at_edge;
	logic [7:0]        tick_n;
	logic [7:0]        div;
	logic              take_step;
	logic [ADDR_W-1:0] pos_adv;
	logic [LEN_W-1:0]  len_sat;

	always_comb begin
		rem = (LEN_W'(pos_q) <= len_q) ? (len_q - LEN_W'(pos_q)) : '0;
		fits = (CMP_W'(len_q) <= CMP_W'(gap)) ||
			((CMP_W'(len_q) - CMP_W'(gap)) <= CMP_W'(width));
		at_edge = (pos_q == '0) || (CMP_W'(rem) == (CMP_W'(gap) + CMP_W'(width)));
		tick_n = tick_q + 8'd1;
		div = (step_divide == 8'd0) ? 8'd1 : step_divide;
		take_step = (tick_n >= div);
		pos_adv = ((LEN_W'(pos_q) + LEN_W'(1)) >= len_q) ? '0 : (pos_q + ADDR_W'(1));
		len_sat = (int'(new_length) > TEXT_DEPTH) ? LEN_W'(TEXT_DEPTH) : LEN_W'(new_length);
	end

	assign snap.pos   = pos_q;
	assign snap.rem   = rem;
	assign snap.fits  = fits;
	assign snap.width = width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			pos_q   <= '0;
			pause_q <= '0;
			tick_q  <= '0;
		end else if (commit_en) begin
			len_q <= len_sat;
			if (restart) begin
				pos_q   <= '0;
				pause_q <= '0;
				tick_q  <= '0;
			end else if (LEN_W'(pos_q) >= len_sat) begin
				pos_q <= '0;
			end
		end else if (tick_en) begin
			tick_q <= take_step ? 8'd0 : tick_n;
			if (take_step) begin
				if (at_edge && (pause_q < edge_pause)) begin
					pause_q <= pause_q + 8'd1;
				end else begin
					pause_q <= '0;
					pos_q   <= pos_adv;
				end
				if (fits)
					pos_q <= '0;
			end
		end
	end

endmodule

[hw/rtl/stw_frame.sv]
module stw_frame import stw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  frame_req_t        snap,
	output logic              busy,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [CHAR_W-1:0] rd_data,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [CHAR_W-1:0] out_char,
	output logic              char_valid,
	output logic              last_column
);

	logic              busy_q;
	logic [COL_W-1:0]  col_q;
	frame_req_t        req_q;

	logic              v_s1;
	logic              blank_s1;
	logic              last_s1;

	logic              res_v_q;
	logic [CHAR_W-1:0] char_q;
	logic              cvalid_q;
	logic              last_q;

	logic              in_text;
	logic              col_blank;
	logic              col_last;
	logic              move_s1;
	logic              issue;

	always_comb begin
		in_text   = CMP_W'(col_q) < CMP_W'(req_q.rem);
		col_blank = !in_text && req_q.fits;
		col_last  = (CMP_W'(col_q) + CMP_W'(1)) == CMP_W'(req_q.width);
		// wrap-around columns restart from the head of the text
		rd_addr   = in_text ? (req_q.pos + ADDR_W'(col_q))
			: (ADDR_W'(col_q) - ADDR_W'(req_q.rem));
		move_s1   = v_s1 && (!res_v_q || result_ready);
		issue     = busy_q && (!v_s1 || move_s1);
	end

	assign rd_en = issue;
	assign busy  = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			col_q  <= '0;
		end else if (issue) begin
			col_q <= col_last ? '0 : (col_q + COL_W'(1));
			if (col_last)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			req_q <= snap;
	end

	// read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (issue) begin
			v_s1 <= 1'b1;
		end else if (move_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			blank_s1 <= col_blank;
			last_s1  <= col_last;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (move_s1) begin
			res_v_q <= 1'b1;
		end else if (result_ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			char_q   <= blank_s1 ? '0 : rd_data;
			cvalid_q <= !blank_s1;
			last_q   <= last_s1;
		end
	end

	assign result_valid = res_v_q;
	assign out_char     = char_q;
	assign char_valid   = cvalid_q;
	assign last_column  = last_q;

endmodule

[hw/rtl/stw_checker.sv]
`include "scrolling_text_window_assert.svh"

module stw_checker import stw_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic [1:0] kind,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] out_char,
	input logic       char_valid,
	input logic       last_column
);

	// a stalled result keeps its payload
	`STW_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(out_char) && $stable(char_valid) && $stable(last_column), "result changed while stalled")

	// blank columns carry a zero character
	`STW_ASSERT_NOW(a_blank_zero, result_valid && !char_valid, out_char == 8'd0, "blank column with nonzero character")

	// a tick occupies the store read port for its frame
	`STW_ASSERT_NEXT(a_tick_busy, item_valid && item_ready && (kind == KIND_TICK), !item_ready, "ready after tick request")

	// writes, commits and ignored kinds never block the next request
	`STW_ASSERT_NEXT(a_short_ready, item_valid && item_ready && (kind != KIND_TICK), item_ready, "ready dropped after one-cycle request")

endmodule

bind scrolling_text_window stw_checker u_stw_checker (.*);

[test/tb_scrolling_text_window.sv]
`timescale 1ns / 100ps

class frame_tracker;

	typedef struct {
		bit [7:0] ch;
		bit       valid;
		bit       is_last;
	} column_t;

	bit [7:0] text_mem [stw_pkg::TEXT_DEPTH];
	bit       written [stw_pkg::TEXT_DEPTH];
	bit [8:0] text_len;
	bit [7:0] scroll_pos;
	bit [7:0] pause_cnt;
	bit [7:0] tick_cnt;

	bit [5:0] width_reg;
	bit [3:0] gap_reg;
	bit [7:0] divide_reg;
	bit [7:0] pause_reg;

	column_t due_columns [$];

	int errors;
	int requests;
	int frames;
	int columns_checked;
	int holds;
	int advances;
	int wraps;

	function new();
		text_len   = '0;
		scroll_pos = '0;
		pause_cnt  = '0;
		tick_cnt   = '0;
		width_reg  = 6'd16;
		gap_reg    = 4'd4;
		divide_reg = 8'd8;
		pause_reg  = 8'd10;
	endfunction

	function int unsigned eff_cols();
		if (width_reg == 0)
			return 1;
		if (width_reg > stw_pkg::MAX_WINDOW)
			return stw_pkg::MAX_WINDOW;
		return width_reg;
	endfunction

	function void set_reg(stw_pkg::reg_idx_t idx, bit [31:0] value);
		case (idx)
			stw_pkg::REG_WINDOW_WIDTH: width_reg  = value[5:0];
			stw_pkg::REG_GAP_LENGTH:   gap_reg    = value[3:0];
			stw_pkg::REG_STEP_DIVIDE:  divide_reg = value[7:0];
			stw_pkg::REG_EDGE_PAUSE:   pause_reg  = value[7:0];
			default: ;
		endcase
	endfunction

	function void take_request(bit [1:0] k, bit [7:0] p, bit [7:0] c, bit [8:0] n, bit r);
		int unsigned w, len, pos, rem, div, col_idx;
		bit fits;
		column_t col;
		requests++;
		if (k == stw_pkg::KIND_WRITE) begin
			text_mem[p] = c;
			written[p]  = 1'b1;
		end else if (k == stw_pkg::KIND_COMMIT) begin
			text_len = (n > stw_pkg::TEXT_DEPTH) ? 9'(stw_pkg::TEXT_DEPTH) : n;
			if (r) begin
				scroll_pos = '0;
				pause_cnt  = '0;
				tick_cnt   = '0;
			end else if (scroll_pos >= text_len) begin
				scroll_pos = '0;
			end
		end else if (k == stw_pkg::KIND_TICK) begin
			frames++;
			w    = eff_cols();
			len  = text_len;
			pos  = scroll_pos;
			rem  = (pos <= len) ? len - pos : 0;
			fits = (len <= gap_reg) || (len - gap_reg <= w);
			div  = (divide_reg == 0) ? 1 : divide_reg;
			for (col_idx = 0; col_idx < w; col_idx++) begin
				col.ch    = 8'h00;
				col.valid = 1'b0;
				if (col_idx < rem) begin
					col.ch    = text_mem[(pos + col_idx) % stw_pkg::TEXT_DEPTH];
					col.valid = 1'b1;
				end else if (!fits) begin
					col.ch    = text_mem[(col_idx - rem) % stw_pkg::TEXT_DEPTH];
					col.valid = 1'b1;
				end
				col.is_last = (col_idx + 1 == w);
				due_columns.push_back(col);
			end
			tick_cnt = tick_cnt + 8'd1;
			if (tick_cnt >= div) begin
				tick_cnt = '0;
				if ((pos == 0 || rem == gap_reg + w) && pause_cnt < pause_reg) begin
					pause_cnt = pause_cnt + 8'd1;
					holds++;
				end else begin
					pause_cnt = '0;
					pos = pos + 1;
					advances++;
					if (pos >= len) begin
						pos = 0;
						wraps++;
					end
					scroll_pos = 8'(pos);
				end
				if (fits)
					scroll_pos = '0;
			end
		end
	endfunction

	function void check_column(bit [7:0] ch, bit v, bit is_last);
		column_t want;
		if (due_columns.size() == 0) begin
			$error("column with nothing due: out_char %0h char_valid %0b last_column %0b",
				ch, v, is_last);
			errors++;
			return;
		end
		want = due_columns.pop_front();
		columns_checked++;
		if (want.ch !== ch) begin
			$error("out_char: expected %0h, got %0h", want.ch, ch);
			errors++;
		end
		if (want.valid !== v) begin
			$error("char_valid: expected %0b, got %0b", want.valid, v);
			errors++;
		end
		if (want.is_last !== is_last) begin
			$error("last_column: expected %0b, got %0b", want.is_last, is_last);
			errors++;
		end
	endfunction

endclass

module tb_scrolling_text_window;
	import stw_pkg::*;

	// generous bound on the whole run, far beyond the slowest legal schedule
	localparam int CYCLE_LIMIT = 1000000;

	logic               clk;
	logic               arst_n      = 1'b0;

	logic               psel        = 1'b0;
	logic               penable     = 1'b0;
	logic               pwrite      = 1'b0;
	logic [PADDR_W-1:0] paddr       = '0;
	logic [PDATA_W-1:0] pwdata      = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	logic               item_valid  = 1'b0;
	logic               item_ready;
	logic [1:0]         kind        = KIND_WRITE;
	logic [7:0]         position    = '0;
	logic [7:0]         char_value  = '0;
	logic [8:0]         new_length  = '0;
	logic               restart     = 1'b0;

	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [7:0]         out_char;
	logic               char_valid;
	logic               last_column;

	frame_tracker sb = new();

	// idle rates in percent, and a long receiver hold-off counted by the receiver
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_hold     = 0;
	int cycles        = 0;
	int settings      = 1;

	scrolling_text_window DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.position     (position),
		.char_value   (char_value),
		.new_length   (new_length),
		.restart      (restart),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_char     (out_char),
		.char_valid   (char_valid),
		.last_column  (last_column)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timed out after %0d cycles with %0d columns still due",
					cycles, sb.due_columns.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	// receiver: random back-pressure, or a solid hold-off while recv_hold runs down
	initial begin
		forever begin
			@(posedge clk);
			if (recv_hold > 0) begin
				recv_hold--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// result monitor: values sampled here are the ones held before the edge
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready)
				sb.check_column(out_char, char_valid, last_column);
		end
	end

	// one apb transfer: setup phase, access phase until pready, then an idle phase
	task automatic apb_access(input logic [PADDR_W-1:0] addr, input logic wr,
		input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// write a register, mirror it in the tracker and read it back
	task automatic set_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] mask;
		logic [31:0] rd;
		logic [PADDR_W-1:0] addr;
		mask = (idx == REG_WINDOW_WIDTH) ? 32'h3F : (idx == REG_GAP_LENGTH) ? 32'hF : 32'hFF;
		addr = PADDR_W'({idx, 2'b00});
		apb_access(addr, 1'b1, value, rd);
		sb.set_reg(idx, value);
		apb_access(addr, 1'b0, '0, rd);
		if ((rd & mask) !== (value & mask)) begin
			$error("%s readback: expected %0h, got %0h", idx.name(), value & mask, rd & mask);
			sb.errors++;
		end
	endtask

	task automatic configure(input int ww, input int gap, input int div, input int pause);
		set_reg(REG_WINDOW_WIDTH, ww);
		set_reg(REG_GAP_LENGTH, gap);
		set_reg(REG_STEP_DIVIDE, div);
		set_reg(REG_EDGE_PAUSE, pause);
		settings++;
	endtask

	// offer one request, holding it until the handshake, then record it
	task automatic send_request(input logic [1:0] k, input logic [7:0] p, input logic [7:0] c,
		input logic [8:0] n, input logic r);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		kind       <= k;
		position   <= p;
		char_value <= c;
		new_length <= n;
		restart    <= r;
		do @(posedge clk); while (!item_ready);
		sb.take_request(k, p, c, n, r);
	endtask

	task automatic put_char(input logic [7:0] p, input logic [7:0] c);
		send_request(KIND_WRITE, p, c, 9'($urandom_range(511)), 1'($urandom));
	endtask

	task automatic tick();
		send_request(KIND_TICK, 8'($urandom), 8'($urandom), 9'($urandom_range(511)),
			1'($urandom));
	endtask

	// every entry the new text covers gets written first, so no frame reads an empty slot
	task automatic commit_length(input int len, input logic r);
		int span;
		int a;
		span = (len > TEXT_DEPTH) ? TEXT_DEPTH : len;
		for (a = 0; a < span; a++)
			if (!sb.written[a])
				put_char(8'(a), 8'($urandom));
		send_request(KIND_COMMIT, 8'($urandom), 8'($urandom), 9'(len), r);
	endtask

	// stop offering and let every due column come out, plus a little slack
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.due_columns.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_idling(input int s, input int r);
		send_idle_pct = s;
		recv_idle_pct = r;
	endtask

	// random traffic until frame_goal more frames are out
	task automatic run_random(input int frame_goal, input bit force_long, input bit squeeze);
		int stop_at;
		int roll;
		int len;
		int span;
		int w;
		stop_at = sb.frames + frame_goal;
		// saturating length: above the store depth, covers the whole store
		if (force_long) begin
			commit_length($urandom_range(257, 511), 1'b1);
			repeat (6) tick();
		end
		while (sb.frames < stop_at) begin
			roll = $urandom_range(99);
			if (roll < 65) begin
				// well-formed: touch up a few characters, commit, then run frames
				w = sb.eff_cols();
				case ($urandom_range(9))
					0, 1:    len = w + sb.gap_reg + $urandom_range(2) - 1;
					2:       len = $urandom_range(25, 64);
					3:       len = ($urandom_range(3) == 0) ? $urandom_range(65, 511) : 
						$urandom_range(1, 24);
					default: len = $urandom_range(1, 24);
				endcase
				if (len < 0)
					len = 0;
				span = (len > TEXT_DEPTH) ? TEXT_DEPTH : len;
				if (span > 0)
					repeat ($urandom_range(4))
						put_char(8'($urandom_range(span - 1)), 8'($urandom));
				commit_length(len, $urandom_range(3) != 0);
				repeat ($urandom_range(3, 12)) tick();
			end else if (roll < 85) begin
				// noise: stray writes, odd commits, lone frames, unknown kind
				case ($urandom_range(3))
					0: put_char(8'($urandom), 8'($urandom));
					1: commit_length(($urandom_range(9) == 0) ? $urandom_range(511) :
						$urandom_range(64), 1'($urandom));
					2: tick();
					default: send_request(2'd3, 8'($urandom), 8'($urandom),
						9'($urandom_range(511)), 1'($urandom));
				endcase
			end else begin
				// broken sequence: shrink the text mid-scroll without a restart
				commit_length($urandom_range(sb.text_len), 1'b0);
				repeat ($urandom_range(1, 4)) tick();
			end
			// back-pressure burst: receiver holds off while the sender keeps offering
			// full frames, then the sender waits out every due column
			if (squeeze && sb.frames >= stop_at - frame_goal / 2) begin
				squeeze = 1'b0;
				recv_hold = 400;
				repeat (6) tick();
				drain();
			end
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase one: sender mostly busy, receiver mostly stalling
		set_idling(8, 65);

		// directed, reset register values: empty text, ignored kind, short fitting text
		tick();
		send_request(2'd3, 8'hFF, 8'hFF, 9'h1FF, 1'b1);
		put_char(8'd0, 8'h00);
		put_char(8'd1, 8'hFF);
		put_char(8'd2, 8'h5A);
		commit_length(3, 1'b0);
		tick();
		drain();

		// directed, narrow window, no gap, zero divider: every frame is a scroll step or an edge hold
		configure(4, 0, 0, 1);
		put_char(8'd3, 8'h80);
		put_char(8'd4, 8'h01);
		put_char(8'd5, 8'h7F);
		// six characters in a four wide window: start pause, scroll, right-end pause,
		// wrapped reads from the front of the text
		commit_length(6, 1'b1);
		repeat (7) tick();
		// shrinking commit behind the scroll position snaps it back to the start
		commit_length(2, 1'b0);
		tick();
		// text exactly as wide as the window still fits
		commit_length(4, 1'b0);
		tick();
		// one character more no longer fits
		commit_length(5, 1'b0);
		tick();
		drain();

		// random phases, each under its own register setting
		configure(8, 3, 1, 2);
		run_random(5, 1'b1, 1'b0);

		configure(32, 15, 0, 0);
		run_random(5, 1'b0, 1'b1);

		// phase two: sender mostly idle, receiver mostly ready
		set_idling(65, 8);
		configure(0, 0, 2, 1);
		run_random(5, 1'b0, 1'b0);

		configure(63, 7, 255, 255);
		run_random(5, 1'b0, 1'b0);

		// phase three: no idling on either side
		set_idling(0, 0);
		configure(16, 4, 8, 10);
		run_random(5, 1'b0, 1'b0);

		configure(5, 1, 1, 0);
		run_random(5, 1'b0, 1'b0);

		$display("ran %0d requests and %0d frames under %0d register settings, %0d columns checked",
			sb.requests, sb.frames, settings, sb.columns_checked);
		$display("scroll activity: %0d edge holds, %0d steps, %0d wraps to the start",
			sb.holds, sb.advances, sb.wraps);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/stw_pkg.sv
hw/rtl/stw_ram.sv
hw/rtl/stw_scroll.sv
hw/rtl/stw_frame.sv
hw/rtl/scrolling_text_window.sv
hw/rtl/stw_checker.sv
test/tb_scrolling_text_window.sv
